// ----- sv/assert_macros.svh -----
// assertion macros used by the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked at every rising clock edge outside reset
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// implication checked in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ----- sv/hvt_pkg.sv -----
// package for the homogeneous vector transform: widths, op codes, queue entry type
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package hvt_pkg;
   localparam int FracBits   = 16;
   localparam int NumRegs    = 8;
   localparam int QBits      = 33;
   localparam int DivSteps   = QBits;

   typedef enum logic [1:0] {
      OP_NORMAL = 2'd0,
      OP_AFFINE = 2'd1,
      OP_HOMOG  = 2'd2,
      OP_NONE   = 2'd3
   } op_type;

   // one classified item after the dot products, sent from front to back
   typedef struct packed {
      op_type             op;
      logic signed [65:0] num_x;
      logic signed [65:0] num_y;
      logic signed [65:0] num_z;
      logic signed [65:0] num_w;
   } item_type;

   // one finished result
   typedef struct packed {
      logic signed [31:0] out_x;
      logic signed [31:0] out_y;
      logic signed [31:0] out_z;
      logic               zero_w;
      logic               saturated;
   } result_type;

   // clamp a wide value to 32 bits
   function automatic logic [32:0] sat32(input logic signed [65:0] v);
      logic [32:0] r;
      if (v > 66'sd2147483647) r = {1'b1, 32'h7FFFFFFF};
      else if (v < -66'sd2147483648) r = {1'b1, 32'h80000000};
      else r = {1'b0, v[31:0]};
      return r;
   endfunction
endpackage
`default_nettype wire

// ----- sv/hvt_front.sv -----
// front part: matrix registers, products and floored dot products (3 stages)
// depends on hvt_pkg
`timescale 1ns / 1ps
`default_nettype none
module hvt_front (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                csr_valid,
   output logic                     csr_ready,
   input  wire logic [2:0]          csr_index,
   input  wire logic [63:0]         csr_data,
   input  wire logic                in_valid,
   output logic                     in_ready,
   input  wire logic [1:0]          in_op,
   input  wire logic signed [31:0]  in_x,
   input  wire logic signed [31:0]  in_y,
   input  wire logic signed [31:0]  in_z,
   output logic                     out_valid,
   input  wire logic                out_ready,
   output hvt_pkg::item_type        out_item
);
   import hvt_pkg::*;

   logic [63:0] regs_ff [NumRegs];
   logic signed [31:0] m [4][4];
   logic [2:0]  v_ff;
   logic        adv;
   logic [1:0]  op1_ff, op2_ff;
   logic signed [63:0] p_ff [3][4];
   logic signed [31:0] t_ff [4];
   logic signed [65:0] s_ff [4];

   assign csr_ready = 1'b1;

   // configuration register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NumRegs; i++) regs_ff[i] <= '0;
      end else if (csr_valid) begin
         regs_ff[csr_index] <= csr_data;
      end
   end

   // matrix entries from register halves
   always_comb begin
      for (int r = 0; r < 4; r++) begin
         m[r][0] = regs_ff[2*r][31:0];
         m[r][1] = regs_ff[2*r][63:32];
         m[r][2] = regs_ff[2*r+1][31:0];
         m[r][3] = regs_ff[2*r+1][63:32];
      end
   end

   // pipeline moves when the last stage is empty or taken
   assign adv       = !v_ff[2] || out_ready;
   assign in_ready  = adv;
   assign out_valid = v_ff[2];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (adv) begin
         v_ff <= {v_ff[1:0], in_valid};
      end
   end

   // stage 1: twelve products, translation captured (zero for OP_NORMAL)
   always_ff @(posedge clock) begin
      if (adv) begin
         op1_ff <= in_op;
         for (int c = 0; c < 4; c++) begin
            p_ff[0][c] <= in_x * m[0][c];
            p_ff[1][c] <= in_y * m[1][c];
            p_ff[2][c] <= in_z * m[2][c];
            t_ff[c]    <= (in_op == OP_NORMAL) ? 32'sd0 : m[3][c];
         end
      end
   end

   // stage 2: exact sum with translation aligned, then floor shift
   always_ff @(posedge clock) begin
      if (adv) begin
         op2_ff <= op1_ff;
         for (int c = 0; c < 4; c++) begin
            s_ff[c] <= (66'(p_ff[0][c]) + 66'(p_ff[1][c]) + 66'(p_ff[2][c])
                        + (66'(t_ff[c]) <<< FracBits)) >>> FracBits;
         end
      end
   end

   // stage 3 register
   always_ff @(posedge clock) begin
      if (adv) begin
         out_item.op    <= op_type'(op2_ff);
         out_item.num_x <= s_ff[0];
         out_item.num_y <= s_ff[1];
         out_item.num_z <= s_ff[2];
         out_item.num_w <= s_ff[3];
      end
   end
endmodule
`default_nettype wire

// ----- sv/hvt_queue.sv -----
// short queue between front and back parts
// depends on hvt_pkg
`timescale 1ns / 1ps
`default_nettype none
module hvt_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_valid,
   output logic                   in_ready,
   input  hvt_pkg::item_type      in_item,
   output logic                   out_valid,
   input  wire logic              out_ready,
   output hvt_pkg::item_type      out_item
);
   import hvt_pkg::*;

   item_type    mem_ff [2];
   logic        wp_ff, rp_ff;
   logic [1:0]  cnt_ff;
   logic        wr, rd;

   assign in_ready  = (cnt_ff != 2'd2);
   assign out_valid = (cnt_ff != 2'd0);
   assign wr = in_valid && in_ready;
   assign rd = out_valid && out_ready;
   assign out_item = mem_ff[rp_ff];

   // storage
   always_ff @(posedge clock) begin
      if (wr) mem_ff[wp_ff] <= in_item;
   end

   // pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= 1'b0; rp_ff <= 1'b0; cnt_ff <= '0;
      end else begin
         if (wr) wp_ff <= !wp_ff;
         if (rd) rp_ff <= !rp_ff;
         cnt_ff <= cnt_ff + 2'(wr) - 2'(rd);
      end
   end
endmodule
`default_nettype wire

// ----- sv/hvt_back.sv -----
// back part: pipelined restoring divide (33 quotient bits) for the homogeneous mode, saturation
// depends on hvt_pkg
`timescale 1ns / 1ps
`default_nettype none
module hvt_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_valid,
   output logic                   in_ready,
   input  hvt_pkg::item_type      in_item,
   output logic                   out_valid,
   input  wire logic              out_ready,
   output hvt_pkg::result_type    out_res
);
   import hvt_pkg::*;

   localparam int DB     = 66;                 // magnitude and divisor width
   localparam int RB     = DB + 1;             // partial remainder width
   localparam int LoBits = QBits - FracBits;   // magnitude bits in the low dividend part

   // stage 0 is the entry register, stage s+1 holds the result of divide step s
   logic [DivSteps:0]          v_ff;
   op_type                     op_ff  [DivSteps+1];
   logic [2:0]                 neg_ff [DivSteps+1];
   logic [2:0]                 ovf_ff [DivSteps+1];
   logic [DB-1:0]              d_ff   [DivSteps+1];
   logic [32:0]                dir_ff [DivSteps+1][3];
   logic [RB-1:0]              r_ff   [DivSteps][3];
   logic [QBits-1:0]           lo_ff  [DivSteps][3];
   logic [QBits-1:0]           q_ff   [DivSteps][3];
   logic                       adv;
   logic signed [65:0]         num [3];
   logic signed [65:0]         w;
   logic [DB-1:0]              wmag;
   logic [DB-1:0]              nmag [3];
   logic [RB-1:0]              rt  [DivSteps][3];
   logic                       ge  [DivSteps][3];
   logic [QBits-1:0]           q;
   logic [32:0]                cq  [3];
   logic                       zero;

   assign adv      = !v_ff[DivSteps] || out_ready;
   assign in_ready = adv;
   assign out_valid = v_ff[DivSteps];

   always_ff @(posedge clock) begin
      if (reset) v_ff <= '0;
      else if (adv) v_ff <= {v_ff[DivSteps-1:0], in_valid};
   end

   assign num[0] = in_item.num_x;
   assign num[1] = in_item.num_y;
   assign num[2] = in_item.num_z;
   assign w      = in_item.num_w;

   // magnitudes of numerators and divisor
   always_comb begin
      wmag = w[65] ? DB'(-w) : DB'(w);
      for (int k = 0; k < 3; k++)
         nmag[k] = num[k][65] ? DB'(-num[k]) : DB'(num[k]);
   end

   // entry: signs, quotient overflow test, first remainder, direct saturation
   always_ff @(posedge clock) begin
      if (adv) begin
         op_ff[0] <= in_item.op;
         d_ff[0]  <= wmag;
         for (int k = 0; k < 3; k++) begin
            neg_ff[0][k] <= num[k][65] ^ w[65];
            ovf_ff[0][k] <= (nmag[k] >> LoBits) >= wmag;
            r_ff[0][k]   <= RB'(nmag[k] >> LoBits);
            lo_ff[0][k]  <= {nmag[k][LoBits-1:0], FracBits'(0)};
            dir_ff[0][k] <= sat32(num[k]);
         end
      end
   end

   // restoring step for each stage, next dividend bit shifted in
   always_comb begin
      for (int s = 0; s < DivSteps; s++)
         for (int k = 0; k < 3; k++) begin
            rt[s][k] = {r_ff[s][k][DB-1:0], lo_ff[s][k][QBits-1]};
            ge[s][k] = (rt[s][k] >= {1'b0, d_ff[s]});
         end
   end

   // side data travels with each stage
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int s = 0; s < DivSteps; s++) begin
            op_ff[s+1]  <= op_ff[s];
            neg_ff[s+1] <= neg_ff[s];
            ovf_ff[s+1] <= ovf_ff[s];
            d_ff[s+1]   <= d_ff[s];
            for (int k = 0; k < 3; k++) dir_ff[s+1][k] <= dir_ff[s][k];
         end
      end
   end

   // remainders, dividend bits and quotient bits
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < 3; k++) q_ff[0][k] <= QBits'(ge[0][k]);
         for (int s = 1; s < DivSteps; s++)
            for (int k = 0; k < 3; k++)
               q_ff[s][k] <= {q_ff[s-1][k][QBits-2:0], ge[s][k]};
         for (int s = 0; s < DivSteps - 1; s++)
            for (int k = 0; k < 3; k++) begin
               r_ff[s+1][k]  <= ge[s][k] ? rt[s][k] - {1'b0, d_ff[s]} : rt[s][k];
               lo_ff[s+1][k] <= lo_ff[s][k] << 1;
            end
      end
   end

   // signed quotient with saturation
   always_comb begin
      zero = (d_ff[DivSteps] == '0);
      q = '0;
      for (int k = 0; k < 3; k++) begin
         q = q_ff[DivSteps-1][k];
         if (ovf_ff[DivSteps][k])
            cq[k] = neg_ff[DivSteps][k] ? {1'b1, 32'h80000000} : {1'b1, 32'h7FFFFFFF};
         else if (neg_ff[DivSteps][k])
            cq[k] = (q > 33'h0_8000_0000) ? {1'b1, 32'h80000000} : {1'b0, -q[31:0]};
         else
            cq[k] = (q > 33'h0_7FFF_FFFF) ? {1'b1, 32'h7FFFFFFF} : {1'b0, q[31:0]};
      end
   end

   // output select: divided result, zero w, passthrough or undefined op
   always_comb begin
      out_res = '0;
      unique case (op_ff[DivSteps])
         OP_NORMAL, OP_AFFINE: begin
            out_res.out_x = dir_ff[DivSteps][0][31:0];
            out_res.out_y = dir_ff[DivSteps][1][31:0];
            out_res.out_z = dir_ff[DivSteps][2][31:0];
            out_res.saturated = dir_ff[DivSteps][0][32] | dir_ff[DivSteps][1][32]
                                | dir_ff[DivSteps][2][32];
         end
         OP_HOMOG: begin
            if (zero) begin
               out_res.zero_w = 1'b1;
            end else begin
               out_res.out_x = cq[0][31:0];
               out_res.out_y = cq[1][31:0];
               out_res.out_z = cq[2][31:0];
               out_res.saturated = cq[0][32] | cq[1][32] | cq[2][32];
            end
         end
         default: out_res = '0;
      endcase
   end
endmodule
`default_nettype wire

// ----- sv/homogeneous_vec3_transform.sv -----
// homogeneous_vec3_transform: result registered through 3 front stages, the queue,
// the back entry stage and 33 divide steps
// throughput one vector per cycle while rsp_tready holds; a 2-entry queue lets front and back stall apart
// synchronous active-high reset clears valids and matrix registers to zero
// depends on hvt_pkg, hvt_front, hvt_queue, hvt_back
`timescale 1ns / 1ps
`default_nettype none
module homogeneous_vec3_transform (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          csr_valid,
   output logic               csr_ready,
   input  wire logic [2:0]    csr_index,
   input  wire logic [63:0]   csr_data,
   input  wire logic          req_tvalid,
   output logic               req_tready,
   input  wire logic [95:0]   req_tdata,  // in_x, in_y, in_z
   input  wire logic [1:0]    req_tuser,  // op
   output logic               rsp_tvalid,
   input  wire logic          rsp_tready,
   output logic [95:0]        rsp_tdata,  // out_x, out_y, out_z
   output logic [1:0]         rsp_tuser   // zero_w, saturated
);
   import hvt_pkg::*;

   item_type   f_item, q_item;
   result_type res;
   logic f_valid, f_ready, q_valid, q_ready;

   hvt_front u_front (
      .clock, .reset, .csr_valid, .csr_ready, .csr_index, .csr_data,
      .in_valid(req_tvalid), .in_ready(req_tready), .in_op(req_tuser),
      .in_x(req_tdata[31:0]), .in_y(req_tdata[63:32]), .in_z(req_tdata[95:64]),
      .out_valid(f_valid), .out_ready(f_ready), .out_item(f_item)
   );

   hvt_queue u_queue (
      .clock, .reset, .in_valid(f_valid), .in_ready(f_ready), .in_item(f_item),
      .out_valid(q_valid), .out_ready(q_ready), .out_item(q_item)
   );

   hvt_back u_back (
      .clock, .reset, .in_valid(q_valid), .in_ready(q_ready), .in_item(q_item),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready), .out_res(res)
   );

   assign rsp_tdata = {res.out_z, res.out_y, res.out_x};
   assign rsp_tuser = {res.saturated, res.zero_w};
endmodule
`default_nettype wire

// ----- sv/hvt_checker.sv -----
// port checker for homogeneous_vec3_transform, bound to the top level
// depends on assert_macros.svh
`include "assert_macros.svh"
`timescale 1ns / 1ps
`default_nettype none
module hvt_checker (
   input wire logic         clock,
   input wire logic         reset,
   input wire logic         rsp_tvalid,
   input wire logic         rsp_tready,
   input wire logic [95:0]  rsp_tdata,
   input wire logic [1:0]   rsp_tuser
);
   // result held while stalled
   `ASSERT_NEXT(a_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid)
   // result contents held while stalled
   `ASSERT_NEXT(a_data_hold, clock, reset, rsp_tvalid && !rsp_tready, $stable(rsp_tdata) && $stable(rsp_tuser))
   // zero w result carries zero components and no saturation
   `ASSERT_IMPL(a_zw, clock, reset, rsp_tvalid && rsp_tuser[0], rsp_tdata == '0 && !rsp_tuser[1])
endmodule
bind homogeneous_vec3_transform hvt_checker u_chk (.*);
`default_nettype wire
